// File: rtl/ray_sphere_intersect_macros.svh
// assertion macros for the ray-sphere intersection block
// used by ray_sphere_intersect only, no other dependencies
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// same-cycle implication
`define RSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsi assertion failed");

// next-cycle implication
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsi assertion failed");

`endif

// File: rtl/rsi_pkg.sv
// shared types and widths for the ray-sphere intersection pipeline
// no dependencies
package rsi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int T_WIDTH     = COORD_WIDTH - 1;
   localparam int OC_WIDTH    = COORD_WIDTH + 1;
   localparam int A_WIDTH     = 2 * COORD_WIDTH;
   localparam int B_WIDTH     = 2 * COORD_WIDTH + 2;
   localparam int BM_WIDTH    = 2 * COORD_WIDTH + 1;
   localparam int C_WIDTH     = 2 * COORD_WIDTH + 3;
   localparam int CM_WIDTH    = 2 * COORD_WIDTH + 2;
   localparam int P_WIDTH     = 4 * COORD_WIDTH + 2;
   localparam int H_WIDTH     = P_WIDTH + 1;
   localparam int SQ_IN_WIDTH = ((H_WIDTH + 2 * FRAC_BITS + 1) / 2) * 2;
   localparam int ROOT_WIDTH  = SQ_IN_WIDTH / 2;
   localparam int REM_WIDTH   = ROOT_WIDTH + 2;
   localparam int N_WIDTH     = ROOT_WIDTH + 1;
   localparam int NS_WIDTH    = ROOT_WIDTH + 2;
   localparam int DV_WIDTH    = ((N_WIDTH > A_WIDTH + T_WIDTH) ? N_WIDTH
                                 : A_WIDTH + T_WIDTH) + 1;
   localparam int BL_WIDTH    = (BM_WIDTH + 1) / 2;
   localparam int BH_WIDTH    = BM_WIDTH - BL_WIDTH;
   localparam int AL_WIDTH    = A_WIDTH / 2;
   localparam int AH_WIDTH    = A_WIDTH - AL_WIDTH;
   localparam int CL_WIDTH    = CM_WIDTH / 2;
   localparam int CH_WIDTH    = CM_WIDTH - CL_WIDTH;

   localparam int QUAD_STAGES = 7;
   localparam int DIV_STAGES  = T_WIDTH + 3;
   localparam int LATENCY     = QUAD_STAGES + ROOT_WIDTH + DIV_STAGES;

   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [T_WIDTH-1:0] T_MAX = {T_WIDTH{1'b1}};
   localparam logic [T_WIDTH-1:0] RADIUS_RESET = T_WIDTH'(1 << FRAC_BITS);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] origin_z;
      logic signed [COORD_WIDTH-1:0] dir_x;
      logic signed [COORD_WIDTH-1:0] dir_y;
      logic signed [COORD_WIDTH-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [T_WIDTH-1:0] t_near;
   } rsp_type;

   // per-ray decisions carried alongside the root search
   typedef struct packed {
      logic                      miss;
      logic                      near;
      logic [A_WIDTH-1:0]        a;
      logic signed [B_WIDTH-1:0] b;
   } side_type;

endpackage

// File: rtl/rsi_quad.sv
// coefficient and discriminant stages: a, b, c and h = b*b - a*c
// depends on rsi_pkg
module rsi_quad
   import rsi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  req_type                in_ray,
   input  logic signed [COORD_WIDTH-1:0] center_x,
   input  logic signed [COORD_WIDTH-1:0] center_y,
   input  logic signed [COORD_WIDTH-1:0] center_z,
   input  logic [T_WIDTH-1:0]     radius,
   output logic                   out_valid,
   output logic [H_WIDTH-1:0]     out_h,
   output side_type               out_side
);

   logic [QUAD_STAGES-1:0] valid_ff, valid_in;

   // stage 0: direction and origin offset
   logic signed [COORD_WIDTH-1:0] d_ff [3];
   logic signed [COORD_WIDTH-1:0] d_in [3];
   logic signed [OC_WIDTH-1:0]    oc_ff [3];
   logic signed [OC_WIDTH-1:0]    oc_in [3];
   // stage 1: products
   logic signed [2*COORD_WIDTH-1:0] dd_ff [3];
   logic signed [2*COORD_WIDTH:0]   doc_ff [3];
   logic signed [2*COORD_WIDTH+1:0] ococ_ff [3];
   logic [2*T_WIDTH-1:0]            rr_ff;
   // stage 2: sums
   logic [A_WIDTH-1:0]        a2_ff, a2_in;
   logic signed [B_WIDTH-1:0] b2_ff, b2_in;
   logic signed [C_WIDTH-1:0] c2_ff, c2_in;
   // stage 3: magnitudes and flags
   logic [A_WIDTH-1:0]        a3_ff;
   logic signed [B_WIDTH-1:0] b3_ff;
   logic [BM_WIDTH-1:0]       bm_ff, bm_in;
   logic [CM_WIDTH-1:0]       cm_ff, cm_in;
   logic                      a_zero3_ff, b_pos3_ff, c_neg3_ff, c_pos3_ff;
   // stage 4: partial products
   logic [A_WIDTH-1:0]              a4_ff;
   logic signed [B_WIDTH-1:0]       b4_ff;
   logic                            a_zero4_ff, b_pos4_ff, c_neg4_ff, c_pos4_ff;
   logic [2*BL_WIDTH-1:0]           bll_ff;
   logic [BL_WIDTH+BH_WIDTH-1:0]    blh_ff;
   logic [2*BH_WIDTH-1:0]           bhh_ff;
   logic [AL_WIDTH+CL_WIDTH-1:0]    pll_ff;
   logic [AL_WIDTH+CH_WIDTH-1:0]    plh_ff;
   logic [AH_WIDTH+CL_WIDTH-1:0]    phl_ff;
   logic [AH_WIDTH+CH_WIDTH-1:0]    phh_ff;
   // stage 5: b*b and a*|c|
   logic [A_WIDTH-1:0]        a5_ff;
   logic signed [B_WIDTH-1:0] b5_ff;
   logic                      a_zero5_ff, b_pos5_ff, c_neg5_ff, c_pos5_ff;
   logic [P_WIDTH-1:0]        bb_ff, bb_in, ac_ff, ac_in;
   // stage 6: discriminant
   logic [P_WIDTH+1:0]        h_in;
   logic [H_WIDTH-1:0]        h_ff;
   side_type                  side_ff, side_in;

   always_comb begin
      d_in[0]  = in_ray.dir_x;
      d_in[1]  = in_ray.dir_y;
      d_in[2]  = in_ray.dir_z;
      oc_in[0] = OC_WIDTH'(in_ray.origin_x) - OC_WIDTH'(center_x);
      oc_in[1] = OC_WIDTH'(in_ray.origin_y) - OC_WIDTH'(center_y);
      oc_in[2] = OC_WIDTH'(in_ray.origin_z) - OC_WIDTH'(center_z);

      a2_in = A_WIDTH'(dd_ff[0]) + A_WIDTH'(dd_ff[1]) + A_WIDTH'(dd_ff[2]);
      b2_in = B_WIDTH'(doc_ff[0]) + B_WIDTH'(doc_ff[1]) + B_WIDTH'(doc_ff[2]);
      c2_in = C_WIDTH'(ococ_ff[0]) + C_WIDTH'(ococ_ff[1]) + C_WIDTH'(ococ_ff[2])
              - C_WIDTH'(rr_ff);

      bm_in = b2_ff[B_WIDTH-1] ? BM_WIDTH'(-b2_ff) : BM_WIDTH'(b2_ff);
      cm_in = c2_ff[C_WIDTH-1] ? CM_WIDTH'(-c2_ff) : CM_WIDTH'(c2_ff);

      bb_in = (P_WIDTH'(bhh_ff) << (2 * BL_WIDTH))
            + (P_WIDTH'(blh_ff) << (BL_WIDTH + 1))
            + P_WIDTH'(bll_ff);
      ac_in = (P_WIDTH'(phh_ff) << (AL_WIDTH + CL_WIDTH))
            + (P_WIDTH'(plh_ff) << CL_WIDTH)
            + (P_WIDTH'(phl_ff) << AL_WIDTH)
            + P_WIDTH'(pll_ff);

      // c below zero flips the sign of the a*c term
      h_in = c_neg5_ff ? ((P_WIDTH+2)'(bb_ff) + (P_WIDTH+2)'(ac_ff))
                       : ((P_WIDTH+2)'(bb_ff) - (P_WIDTH+2)'(ac_ff));

      side_in.miss = a_zero5_ff | h_in[P_WIDTH+1] | (b_pos5_ff & c_pos5_ff);
      side_in.near = ~b_pos5_ff & ~c_neg5_ff;
      side_in.a    = a5_ff;
      side_in.b    = b5_ff;

      valid_in = {valid_ff[QUAD_STAGES-2:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      for (int k = 0; k < 3; k++) begin
         d_ff[k]    <= d_in[k];
         oc_ff[k]   <= oc_in[k];
         dd_ff[k]   <= d_ff[k] * d_ff[k];
         doc_ff[k]  <= d_ff[k] * oc_ff[k];
         ococ_ff[k] <= oc_ff[k] * oc_ff[k];
      end
      rr_ff <= radius * radius;

      a2_ff <= a2_in;
      b2_ff <= b2_in;
      c2_ff <= c2_in;

      a3_ff      <= a2_ff;
      b3_ff      <= b2_ff;
      bm_ff      <= bm_in;
      cm_ff      <= cm_in;
      a_zero3_ff <= (a2_ff == '0);
      b_pos3_ff  <= ~b2_ff[B_WIDTH-1] & (b2_ff != '0);
      c_neg3_ff  <= c2_ff[C_WIDTH-1];
      c_pos3_ff  <= ~c2_ff[C_WIDTH-1] & (c2_ff != '0);

      a4_ff      <= a3_ff;
      b4_ff      <= b3_ff;
      a_zero4_ff <= a_zero3_ff;
      b_pos4_ff  <= b_pos3_ff;
      c_neg4_ff  <= c_neg3_ff;
      c_pos4_ff  <= c_pos3_ff;
      bll_ff <= bm_ff[BL_WIDTH-1:0] * bm_ff[BL_WIDTH-1:0];
      blh_ff <= bm_ff[BL_WIDTH-1:0] * bm_ff[BM_WIDTH-1:BL_WIDTH];
      bhh_ff <= bm_ff[BM_WIDTH-1:BL_WIDTH] * bm_ff[BM_WIDTH-1:BL_WIDTH];
      pll_ff <= a3_ff[AL_WIDTH-1:0] * cm_ff[CL_WIDTH-1:0];
      plh_ff <= a3_ff[AL_WIDTH-1:0] * cm_ff[CM_WIDTH-1:CL_WIDTH];
      phl_ff <= a3_ff[A_WIDTH-1:AL_WIDTH] * cm_ff[CL_WIDTH-1:0];
      phh_ff <= a3_ff[A_WIDTH-1:AL_WIDTH] * cm_ff[CM_WIDTH-1:CL_WIDTH];

      a5_ff      <= a4_ff;
      b5_ff      <= b4_ff;
      a_zero5_ff <= a_zero4_ff;
      b_pos5_ff  <= b_pos4_ff;
      c_neg5_ff  <= c_neg4_ff;
      c_pos5_ff  <= c_pos4_ff;
      bb_ff      <= bb_in;
      ac_ff      <= ac_in;

      h_ff    <= h_in[H_WIDTH-1:0];
      side_ff <= side_in;
   end

   assign out_valid = valid_ff[QUAD_STAGES-1];
   assign out_h     = h_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/rsi_sqrt.sv
// pipelined digit-by-digit square root of h * 2^32, one result bit per stage
// depends on rsi_pkg
module rsi_sqrt
   import rsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [H_WIDTH-1:0]    in_h,
   input  side_type              in_side,
   output logic                  out_valid,
   output logic [ROOT_WIDTH-1:0] out_root,
   output side_type              out_side
);

   logic                   valid_ff [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]   rem_ff   [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]  root_ff  [ROOT_WIDTH];
   logic [SQ_IN_WIDTH-1:0] x_ff     [ROOT_WIDTH];
   side_type               side_ff  [ROOT_WIDTH];

   logic [SQ_IN_WIDTH-1:0] sq_x;

   assign sq_x = SQ_IN_WIDTH'({in_h, {(2 * FRAC_BITS){1'b0}}});

   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_step
      logic                   v_src;
      logic [REM_WIDTH-1:0]   rem_src;
      logic [ROOT_WIDTH-1:0]  root_src;
      logic [SQ_IN_WIDTH-1:0] x_src;
      side_type               side_src;
      logic [REM_WIDTH-1:0]   rem_sh, trial, rem_in;
      logic [ROOT_WIDTH-1:0]  root_in;
      logic                   take;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = sq_x;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign x_src    = x_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      always_comb begin
         // bring down the next two bits and try (4*root + 1)
         rem_sh  = {rem_src[ROOT_WIDTH-1:0], x_src[SQ_IN_WIDTH-1:SQ_IN_WIDTH-2]};
         trial   = {root_src, 2'b01};
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_src[ROOT_WIDTH-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         x_ff[i]    <= x_src << 2;
         side_ff[i] <= side_src;
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];
   assign out_side  = side_ff[ROOT_WIDTH-1];

endmodule

// File: rtl/rsi_div.sv
// root numerator, saturating restoring divide by a, result register
// depends on rsi_pkg
module rsi_div
   import rsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ROOT_WIDTH-1:0] in_root,
   input  side_type              in_side,
   output logic                  out_valid,
   output rsp_type               out_rsp
);

   // numerator stage
   logic                  nv_ff;
   logic                  nmiss_ff;
   logic [A_WIDTH-1:0]    na_ff;
   logic [N_WIDTH-1:0]    n_ff;
   logic [NS_WIDTH-1:0]   bs, rootx, n_in;
   // overflow check stage
   logic                  sv_ff;
   logic                  smiss_ff, ssat_ff;
   logic [A_WIDTH-1:0]    sa_ff;
   logic [DV_WIDTH-1:0]   srem_ff;
   // quotient steps
   logic                  valid_ff [T_WIDTH];
   logic                  miss_ff  [T_WIDTH];
   logic                  sat_ff   [T_WIDTH];
   logic [A_WIDTH-1:0]    a_ff     [T_WIDTH];
   logic [DV_WIDTH-1:0]   rem_ff   [T_WIDTH];
   logic [T_WIDTH-1:0]    q_ff     [T_WIDTH];
   // result register
   logic                  ov_ff;
   rsp_type               rsp_ff, rsp_in;

   always_comb begin
      bs    = -(NS_WIDTH'(in_side.b) << FRAC_BITS);
      rootx = NS_WIDTH'(in_root);
      n_in  = in_side.near ? (bs - rootx) : (bs + rootx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
         sv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         nv_ff <= in_valid;
         sv_ff <= nv_ff;
         ov_ff <= valid_ff[T_WIDTH-1];
      end
      nmiss_ff <= in_side.miss;
      na_ff    <= in_side.a;
      n_ff     <= n_in[N_WIDTH-1:0];

      smiss_ff <= nmiss_ff;
      sa_ff    <= na_ff;
      ssat_ff  <= (DV_WIDTH'(n_ff) >= (DV_WIDTH'(na_ff) << T_WIDTH));
      srem_ff  <= DV_WIDTH'(n_ff);

      rsp_ff <= rsp_in;
   end

   for (genvar k = 0; k < T_WIDTH; k++) begin : g_step
      localparam int Shift = T_WIDTH - 1 - k;
      logic                v_src, miss_src, sat_src;
      logic [A_WIDTH-1:0]  a_src;
      logic [DV_WIDTH-1:0] rem_src, dvsr;
      logic [T_WIDTH-1:0]  q_src;
      logic                take;

      if (k == 0) begin : g_first
         assign v_src    = sv_ff;
         assign miss_src = smiss_ff;
         assign sat_src  = ssat_ff;
         assign a_src    = sa_ff;
         assign rem_src  = srem_ff;
         assign q_src    = '0;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign miss_src = miss_ff[k-1];
         assign sat_src  = sat_ff[k-1];
         assign a_src    = a_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
      end

      assign dvsr = DV_WIDTH'(a_src) << Shift;
      assign take = (rem_src >= dvsr);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src;
         end
         miss_ff[k] <= miss_src;
         sat_ff[k]  <= sat_src;
         a_ff[k]    <= a_src;
         rem_ff[k]  <= take ? (rem_src - dvsr) : rem_src;
         q_ff[k]    <= q_src | (take ? (T_WIDTH'(1) << Shift) : '0);
      end
   end

   always_comb begin
      rsp_in.hit = ~miss_ff[T_WIDTH-1];
      if (miss_ff[T_WIDTH-1]) begin
         rsp_in.t_near = '0;
      end else if (sat_ff[T_WIDTH-1]) begin
         rsp_in.t_near = T_MAX;
      end else begin
         rsp_in.t_near = q_ff[T_WIDTH-1];
      end
   end

   assign out_valid = ov_ff;
   assign out_rsp   = rsp_ff;

endmodule

// File: rtl/ray_sphere_intersect.sv
// Ray-sphere hit test, fully pipelined: one ray may start every cycle while
// busy is low, and its result strobes out on rsp_valid, with no way to hold
// results off. The depth comes from the 82-step square root pipeline and the
// 31-step divider, with its numerator, range check and result registers, that
// follow seven coefficient stages. busy is high in reset and the cycle after it.
// Sphere center and radius are written through the csr port, always ready;
// the user must do so only while no ray is in flight; the block does not check.
// depends on rsi_pkg, rsi_quad, rsi_sqrt, rsi_div and the macros header
`include "ray_sphere_intersect_macros.svh"

module ray_sphere_intersect
   import rsi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]   csr_data
);

   logic                          busy_ff;
   logic signed [COORD_WIDTH-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [T_WIDTH-1:0]            radius_ff;
   logic                          req_accept, csr_write;

   logic                  q_valid, s_valid;
   logic [H_WIDTH-1:0]    q_h;
   side_type              q_side, s_side;
   logic [ROOT_WIDTH-1:0] s_root;

   assign req_accept = start & ~busy_ff;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign busy       = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= RADIUS_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_CENTER_X: center_x_ff <= csr_data;
               CSR_CENTER_Y: center_y_ff <= csr_data;
               CSR_CENTER_Z: center_z_ff <= csr_data;
               CSR_RADIUS:   radius_ff   <= csr_data[T_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   rsi_quad u_quad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_ray    (req_data),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .radius    (radius_ff),
      .out_valid (q_valid),
      .out_h     (q_h),
      .out_side  (q_side)
   );

   rsi_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_h      (q_h),
      .in_side   (q_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   rsi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `RSI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.t_near == '0)
   `RSI_ASSERT_IMPL(a_latency, clock, reset, rsp_valid, $past(req_accept, LATENCY))
   `RSI_ASSERT_NEXT(a_radius_wr, clock, reset, csr_write && csr_index == CSR_RADIUS, radius_ff == $past(csr_data[T_WIDTH-1:0]))

endmodule
